FILE: src/dia_pkg.sv
`default_nettype none

package dia_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 32;
  localparam int unsigned NumParts = 3;

  localparam logic [CharW-1:0] CHAR_NUL = 8'h00;

  typedef enum logic [1:0] {
    PH_PART_START,
    PH_AFTER_ZERO,
    PH_DIGITS,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_t;

  typedef struct packed {
    phase_t                           phase;
    logic [AddrW-1:0]                 acc;
    base_t                            base;
    logic                             saw_digit;
    logic [1:0]                       part_count;
    logic [NumParts-1:0][CharW-1:0]   part_bytes;
    logic                             failed;
  } parse_st_t;

endpackage

`default_nettype wire

FILE: src/dia_step.sv
`default_nettype none

module dia_step (
  input  wire logic [dia_pkg::CharW-1:0] character,
  input  wire dia_pkg::parse_st_t        cur,
  output      dia_pkg::parse_st_t        nxt,
  output      logic                      ok,
  output      logic [dia_pkg::AddrW-1:0] address
);
  import dia_pkg::*;

  logic             is_dec;
  logic             is_hex_letter;
  logic             is_space;
  logic [3:0]       dig;
  logic [3:0]       let_val;
  base_t            eff_base;
  logic [AddrW-1:0] scaled;
  logic [AddrW-1:0] val;
  logic             fits;

  always_comb begin
    is_dec        = character inside {[8'h30:8'h39]};
    is_hex_letter = character inside {[8'h41:8'h46], [8'h61:8'h66]};
    is_space      = character inside {8'h20, [8'h09:8'h0D]};
    dig           = character[3:0];
    let_val       = character[3:0] + 4'd9;
  end

  always_comb begin
    eff_base = (cur.phase == PH_AFTER_ZERO) ? BASE_OCT : cur.base;
    case (eff_base)
      BASE_OCT: scaled = {cur.acc[AddrW-4:0], 3'b000};
      BASE_HEX: scaled = {cur.acc[AddrW-5:0], 4'b0000};
      default:  scaled = {cur.acc[AddrW-4:0], 3'b000} + {cur.acc[AddrW-2:0], 1'b0};
    endcase
  end

  // next state
  always_comb begin
    nxt = cur;
    if (character == CHAR_NUL) begin
      nxt.phase      = PH_PART_START;
      nxt.acc        = '0;
      nxt.base       = BASE_DEC;
      nxt.saw_digit  = 1'b0;
      nxt.part_count = '0;
      nxt.failed     = 1'b0;
    end else if (!cur.failed && cur.phase != PH_TAIL) begin
      case (cur.phase)
        PH_PART_START: begin
          if (!is_dec) begin
            nxt.failed = 1'b1;
          end else if (dig == 4'd0) begin
            nxt.acc       = '0;
            nxt.saw_digit = 1'b0;
            nxt.phase     = PH_AFTER_ZERO;
          end else begin
            nxt.acc       = AddrW'(dig);
            nxt.saw_digit = 1'b1;
            nxt.base      = BASE_DEC;
            nxt.phase     = PH_DIGITS;
          end
        end
        PH_AFTER_ZERO, PH_DIGITS: begin
          nxt.phase = PH_DIGITS;
          if (cur.phase == PH_AFTER_ZERO && (character == 8'h78 || character == 8'h58)) begin
            nxt.base = BASE_HEX;
          end else begin
            if (cur.phase == PH_AFTER_ZERO) begin
              nxt.base      = BASE_OCT;
              nxt.saw_digit = 1'b1;
            end
            if (is_dec) begin
              if (eff_base == BASE_OCT && dig >= 4'd8) begin
                nxt.failed = 1'b1;
              end else begin
                nxt.acc       = scaled + AddrW'(dig);
                nxt.saw_digit = 1'b1;
              end
            end else if (eff_base == BASE_HEX && is_hex_letter) begin
              nxt.acc       = {cur.acc[AddrW-5:0], let_val};
              nxt.saw_digit = 1'b1;
            end else if (character == 8'h2E) begin
              if (cur.part_count == 2'd3 || cur.acc > AddrW'(8'hFF)) begin
                nxt.failed = 1'b1;
              end else begin
                nxt.part_bytes[cur.part_count] = cur.acc[CharW-1:0];
                nxt.part_count                 = cur.part_count + 2'd1;
                nxt.phase                      = PH_PART_START;
              end
            end else if (is_space) begin
              nxt.phase = PH_TAIL;
            end else begin
              nxt.failed = 1'b1;
            end
          end
        end
        default: nxt = cur;
      endcase
    end
  end

  // end-of-string result
  always_comb begin
    val = (cur.phase == PH_AFTER_ZERO) ? '0 : cur.acc;
    case (cur.part_count)
      2'd0:    fits = 1'b1;
      2'd1:    fits = (val <= AddrW'(24'hFFFFFF));
      2'd2:    fits = (val <= AddrW'(16'hFFFF));
      default: fits = (val <= AddrW'(8'hFF));
    endcase
    ok = !cur.failed && cur.phase != PH_PART_START
         && (cur.phase == PH_AFTER_ZERO || cur.saw_digit) && fits;
    case (cur.part_count)
      2'd0:    address = val;
      2'd1:    address = val | {cur.part_bytes[0], 24'h0};
      2'd2:    address = val | {cur.part_bytes[0], cur.part_bytes[1], 16'h0};
      default: address = val | {cur.part_bytes[0], cur.part_bytes[1], cur.part_bytes[2], 8'h0};
    endcase
    if (!ok) begin
      address = '0;
    end
  end

endmodule

`default_nettype wire

FILE: src/dotted_ipv4_address_parser.sv
// Channel  Dir  Fields (low bit first)         Transfer
// s_*      in   tdata: character [7:0]          s_tvalid & s_tready
// m_*      out  tuser: valid_res; tdata: address m_tvalid & m_tready
//
// One character per cycle while no NUL waits on a stalled result. A character is
// held in the input register, then folded into the parse state; a NUL loads the
// result register as it leaves the input register.
// rst clears parse state and both valid flags; it is synchronous and active high.
// A stalled result blocks only a following NUL; other characters keep flowing.
`default_nettype none

module dotted_ipv4_address_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output      logic                      s_tready,
  input  wire logic [dia_pkg::CharW-1:0] s_tdata,   // character
  output      logic                      m_tvalid,
  input  wire logic                      m_tready,
  output      logic [dia_pkg::AddrW-1:0] m_tdata,   // address
  output      logic [0:0]                m_tuser    // valid_res
);
  import dia_pkg::*;

  logic             s1_valid;
  logic [CharW-1:0] s1_char;
  logic             s1_nul;
  logic             s1_go;
  parse_st_t        st;
  parse_st_t        st_next;
  logic             res_ok;
  logic [AddrW-1:0] res_addr;

  assign s1_nul   = (s1_char == CHAR_NUL);
  assign s1_go    = s1_valid && !(s1_nul && m_tvalid && !m_tready);
  assign s_tready = !s1_valid || s1_go;

  dia_step u_step (
    .character (s1_char),
    .cur       (st),
    .nxt       (st_next),
    .ok        (res_ok),
    .address   (res_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      s1_char <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_PART_START;
      st.acc        <= '0;
      st.base       <= BASE_DEC;
      st.saw_digit  <= 1'b0;
      st.part_count <= '0;
      st.failed     <= 1'b0;
    end else if (s1_go) begin
      st.phase      <= st_next.phase;
      st.acc        <= st_next.acc;
      st.base       <= st_next.base;
      st.saw_digit  <= st_next.saw_digit;
      st.part_count <= st_next.part_count;
      st.failed     <= st_next.failed;
    end
    if (s1_go) begin
      st.part_bytes <= st_next.part_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && s1_nul) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s1_go && s1_nul) begin
      m_tdata <= res_addr;
      m_tuser <= res_ok;
    end
  end

endmodule

`default_nettype wire

FILE: src/dia_checker.sv
`default_nettype none

module dia_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 32'h0)
    else $error("rejected string carries nonzero address");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result present right after reset");

  a_nul_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata == 8'h00 |=> (m_tvalid && !m_tready) or (##1 m_tvalid))
    else $error("no result after end of string");

endmodule

bind dotted_ipv4_address_parser dia_checker u_chk (.*);

`default_nettype wire

FILE: test/dotted_ipv4_address_checker.sv
`default_nettype none

module dotted_ipv4_address_checker
  import dia_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [CharW-1:0] s_tdata,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [AddrW-1:0] m_tdata,
  input  wire logic [0:0]       m_tuser,
  output int                    errors,
  output int                    pending,
  output int                    strings_done,
  output int                    strings_good
);

  typedef struct packed {
    logic             ok;
    logic [AddrW-1:0] addr;
  } verdict_t;

  verdict_t expected_addrs[$];

  phase_t           ph;
  logic [AddrW-1:0] acc;
  base_t            radix;
  logic             have_digit;
  logic [1:0]       dots;
  logic [CharW-1:0] octet [NumParts];
  logic             bad;

  initial begin
    errors = 0;
    pending = 0;
    strings_done = 0;
    strings_good = 0;
  end

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // 16 when c is not a hex letter
  function automatic logic [4:0] letter_value(input logic [7:0] c);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'd16;
  endfunction

  task automatic clear_parse();
    ph = PH_PART_START;
    acc = '0;
    radix = BASE_DEC;
    have_digit = 1'b0;
    dots = '0;
    foreach (octet[i]) octet[i] = '0;
    bad = 1'b0;
  endtask

  task automatic take_digit(input logic [7:0] c);
    logic [4:0]       nib;
    logic [AddrW-1:0] d;
    nib = letter_value(c);
    d = AddrW'(c) - 32'h30;
    if (is_dec(c)) begin
      if (radix == BASE_OCT && c >= "8") begin
        bad = 1'b1;
      end else begin
        case (radix)
          BASE_OCT: acc = acc * 32'd8 + d;
          BASE_HEX: acc = acc * 32'd16 + d;
          default:  acc = acc * 32'd10 + d;
        endcase
        have_digit = 1'b1;
      end
    end else if (radix == BASE_HEX && nib < 5'd16) begin
      acc = {acc[AddrW-5:0], nib[3:0]};
      have_digit = 1'b1;
    end else if (c == ".") begin
      if (dots == 2'd3 || acc > 32'hff) begin
        bad = 1'b1;
      end else begin
        octet[dots] = acc[7:0];
        dots = dots + 2'd1;
        ph = PH_PART_START;
      end
    end else if (is_ws(c)) begin
      ph = PH_TAIL;
    end else begin
      bad = 1'b1;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic             ok;
    logic [AddrW-1:0] a;
    if (c != CHAR_NUL) begin
      if (bad || ph == PH_TAIL) begin
      end else if (ph == PH_PART_START) begin
        if (!is_dec(c)) begin
          bad = 1'b1;
        end else begin
          acc = '0;
          have_digit = 1'b0;
          if (c == "0") begin
            ph = PH_AFTER_ZERO;
          end else begin
            radix = BASE_DEC;
            acc = AddrW'(c) - 32'h30;
            have_digit = 1'b1;
            ph = PH_DIGITS;
          end
        end
      end else if (ph == PH_AFTER_ZERO && (c == "x" || c == "X")) begin
        ph = PH_DIGITS;
        radix = BASE_HEX;
      end else begin
        if (ph == PH_AFTER_ZERO) begin
          ph = PH_DIGITS;
          radix = BASE_OCT;
          have_digit = 1'b1;
        end
        take_digit(c);
      end
    end else begin
      ok = 1'b0;
      a = '0;
      if (!bad && ph != PH_PART_START) begin
        if (ph == PH_AFTER_ZERO) have_digit = 1'b1;
        ok = have_digit;
        a = acc;
        case (dots)
          2'd1: begin
            if (acc > 32'hffffff) ok = 1'b0;
            a = acc | {octet[0], 24'h0};
          end
          2'd2: begin
            if (acc > 32'hffff) ok = 1'b0;
            a = acc | {octet[0], octet[1], 16'h0};
          end
          2'd3: begin
            if (acc > 32'hff) ok = 1'b0;
            a = acc | {octet[0], octet[1], octet[2], 8'h0};
          end
          default: ;
        endcase
      end
      if (!ok) a = '0;
      expected_addrs.push_back('{ok: ok, addr: a});
      strings_done++;
      if (ok) strings_good++;
      clear_parse();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] want,
                                 input logic [AddrW-1:0] got);
    errors++;
    if (errors <= 20)
      $display("mismatch on result %0d: %s expected %h got %h",
               strings_done - expected_addrs.size(), what, want, got);
  endtask

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      clear_parse();
      expected_addrs.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_addrs.size() == 0) begin
          report_mismatch("result with nothing pending", '0, m_tdata);
        end else begin
          exp_v = expected_addrs.pop_front();
          if (m_tuser[0] !== exp_v.ok)
            report_mismatch("valid_res", AddrW'(exp_v.ok), AddrW'(m_tuser[0]));
          if (m_tdata !== exp_v.addr)
            report_mismatch("address", exp_v.addr, m_tdata);
        end
      end
      if (s_tvalid && s_tready) parse_char(s_tdata);
    end
    pending = expected_addrs.size();
  end

endmodule

`default_nettype wire

FILE: test/dotted_ipv4_address_parser_tb.sv
`default_nettype none

module dotted_ipv4_address_parser_tb;
  import dia_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_CHARS = 400;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [CharW-1:0] s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [AddrW-1:0] m_tdata;
  logic [0:0]       m_tuser;

  int errors;
  int pending;
  int strings_done;
  int strings_good;

  logic             squeeze_req = 1'b0;
  logic             gappy;
  int               chars_sent;
  int unsigned      cycles;
  logic [CharW-1:0] text_q[$];

  dotted_ipv4_address_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  dotted_ipv4_address_checker chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .errors       (errors),
    .pending      (pending),
    .strings_done (strings_done),
    .strings_good (strings_good)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  initial begin
    int stall_left;
    int stall_pct;
    int window;
    m_tready = 1'b0;
    stall_left = 0;
    stall_pct = 0;
    window = 0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        m_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        squeeze_req = 1'b0;
      end
      if (window == 0) begin
        window = 128;
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      window--;
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        m_tready = 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_char(input logic [CharW-1:0] c);
    int gap;
    gap = (gappy && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  // transfer the staged text followed by its NUL
  task automatic send_text();
    text_q.push_back(CHAR_NUL);
    gappy = $urandom_range(0, 3) != 0;
    foreach (text_q[i]) send_char(text_q[i]);
    text_q.delete();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic put_number(input logic [AddrW-1:0] v, input base_t radix);
    logic [CharW-1:0] digs[$];
    logic [AddrW-1:0] rest;
    logic [3:0]       d;
    logic             upper;
    rest = v;
    upper = 1'($urandom_range(0, 1));
    case (radix)
      BASE_OCT: begin
        text_q.push_back("0");
        if ($urandom_range(0, 3) == 0) text_q.push_back("0");
        while (rest != 0) begin
          digs.push_front(8'h30 + 8'(rest[2:0]));
          rest = rest >> 3;
        end
      end
      BASE_HEX: begin
        text_q.push_back("0");
        text_q.push_back(upper ? "X" : "x");
        if (rest == 0) digs.push_front("0");
        while (rest != 0) begin
          d = rest[3:0];
          digs.push_front(d < 10 ? 8'h30 + 8'(d) : (upper ? 8'h41 : 8'h61) + 8'(d) - 8'd10);
          rest = rest >> 4;
        end
      end
      default: begin
        if (rest == 0) digs.push_front("0");
        while (rest != 0) begin
          digs.push_front(8'h30 + 8'(rest % 10));
          rest = rest / 10;
        end
      end
    endcase
    foreach (digs[i]) text_q.push_back(digs[i]);
  endtask

  function automatic base_t pick_radix();
    case ($urandom_range(0, 2))
      0: return BASE_OCT;
      1: return BASE_HEX;
      default: return BASE_DEC;
    endcase
  endfunction

  task automatic build_address();
    int               nparts;
    int               width;
    int               r;
    logic [AddrW-1:0] v;
    logic [AddrW-1:0] mask;
    nparts = $urandom_range(1, 4);
    for (int i = 0; i < nparts - 1; i++) begin
      v = ($urandom_range(0, 99) < 8) ? $urandom_range(256, 999) : $urandom_range(0, 255);
      put_number(v, pick_radix());
      text_q.push_back(".");
    end
    width = 32 - 8 * (nparts - 1);
    mask = (width == 32) ? 32'hffffffff : (32'h1 << width) - 1;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // long decimal run, wraps the accumulator
      text_q.push_back(8'h30 + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(10, 14)) text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    end else begin
      v = $urandom & mask;
      if (r < 20 && width < 32) v = mask + 1 + $urandom_range(0, 300);
      else if (r < 35) v = $urandom_range(0, 3);
      else if (r < 45) v = mask;
      put_number(v, pick_radix());
    end
    r = $urandom_range(0, 99);
    if (r < 25) begin
      text_q.push_back($urandom_range(0, 4) == 0 ? 8'h20 : 8'($urandom_range(9, 13)));
      repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(1, 255)));
    end else if (r < 37) begin
      text_q.push_back(8'($urandom_range(1, 255)));
    end else if (r < 42) begin
      text_q.push_back(".");
    end
    if ($urandom_range(0, 99) < 8)
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(1, 255));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    chars_sent = 0;
    gappy = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    send_text();
    put_str("0");          send_text();
    put_str("0x");         send_text();
    put_str("09");         send_text();
    put_str("a");          send_text();
    put_str("256.1");      send_text();
    put_str("0.0.0.0.");   send_text();
    put_str("9z");         send_text();
    put_str("0xfF ");
    text_q.push_back(8'hff);
    send_text();

    squeeze_req = 1'b1;
    while (chars_sent < RANDOM_CHARS) begin
      if ($urandom_range(0, 99) < 80) begin
        build_address();
      end else begin
        repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(1, 255)));
      end
      send_text();
    end
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d characters transferred, %0d strings ended (%0d parsed, %0d rejected)",
             chars_sent, strings_done, strings_good, strings_done - strings_good);
    $display("mixed radix parts, one to four parts, overflow, junk tails and a long output stall");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: dotted_ipv4_address_parser.f
src/dia_pkg.sv
src/dia_step.sv
src/dotted_ipv4_address_parser.sv
src/dia_checker.sv
test/dotted_ipv4_address_checker.sv
test/dotted_ipv4_address_parser_tb.sv
